FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rstn, ante, cons)
`define AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/wsdf_pkg.sv
// Types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsdf_pkg;

    localparam int LENGTH_WIDTH_DEF = 24;
    localparam int LEN_W            = 24;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(1024 * 1024);
    localparam logic [LEN_W-1:0] CTRL_MAX_LEN    = LEN_W'(125);

    localparam logic [7:0] RSV_MASK  = 8'h70;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        K_HEADER = 2'd0,
        K_DATA   = 2'd1,
        K_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        E_RSV   = 3'd0,
        E_MSB   = 3'd1,
        E_FRAG  = 3'd2,
        E_CLOSE = 3'd3,
        E_BIG   = 3'd4
    } t_err;

endpackage

FILE: rtl/websocket_frame_deframer.sv
// WebSocket frame deframer: header parse, payload unmask, error checks.
// An accepted word passes the input and then the result register; i_stall holds both.
// Throughput: one word per cycle unless stalled; each parse is one pass of short logic.
// Words that complete no result (header, length, mask key bytes) produce no output.
// Synchronous active-low reset: parser expects a first header byte, max_payload = 1 MiB.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module websocket_frame_deframer #(
    parameter int LENGTH_WIDTH = wsdf_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_byte_in,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [wsdf_pkg::LEN_W-1:0] i_cfg_max_payload,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_kind,
    output logic                     o_fin_bit,
    output logic [3:0]               o_frame_opcode,
    output logic                     o_was_masked,
    output logic [wsdf_pkg::LEN_W-1:0] o_payload_length,
    output logic [7:0]               o_data_byte,
    output logic [2:0]               o_error_code,
    output logic                     o_last
);
    import wsdf_pkg::*;

    localparam int CMP_W = (LENGTH_WIDTH > LEN_W) ? LENGTH_WIDTH : LEN_W;

    logic [LEN_W-1:0]        r_max;
    logic                    r_in_valid;
    logic [7:0]              r_in_byte;

    t_phase                  r_phase, n_phase;
    logic [2:0]              r_cnt, n_cnt;
    logic                    r_rsv, n_rsv;
    logic [LEN_W-1:0]        r_len, n_len;
    logic                    r_len_hi, n_len_hi;
    logic                    r_top, n_top;
    logic [3:0]              r_opcode, n_opcode;
    logic                    r_fin, n_fin;
    logic                    r_mask, n_mask;
    logic [31:0]             r_key, n_key;
    logic [LENGTH_WIDTH-1:0] r_idx, n_idx;

    logic                    r_out_valid;
    t_kind                   r_kind, n_kind;
    logic                    r_res_fin, n_res_fin;
    logic [3:0]              r_res_op, n_res_op;
    logic                    r_res_mask, n_res_mask;
    logic [LEN_W-1:0]        r_res_len, n_res_len;
    logic [7:0]              r_res_data, n_res_data;
    t_err                    r_res_err, n_res_err;
    logic                    r_res_last, n_res_last;

    logic                    adv;
    logic                    fire;
    logic                    emit;
    logic                    err;
    t_err                    err_code;
    logic                    len_done;
    logic                    hdr_done;
    logic [LEN_W-1:0]        chk_len;
    logic                    chk_hi;
    logic [LEN_W-1:0]        shifted;
    logic                    shift_hi;
    logic [1:0]              key_sel;
    logic [7:0]              key_byte;
    logic [LENGTH_WIDTH-1:0] idx_next;
    logic                    pay_end;

    assign adv         = !(r_out_valid && i_stall);
    assign fire        = r_in_valid && adv;
    assign o_stall     = r_in_valid && !adv;
    assign o_cfg_ready = 1'b1;

    assign shifted  = {r_len[LEN_W-9:0], r_in_byte};
    assign shift_hi = r_len_hi || (r_len[LEN_W-1:LEN_W-8] != 8'd0);
    assign key_sel  = 2'd3 - r_idx[1:0];
    assign key_byte = r_mask ? r_key[{key_sel, 3'b000} +: 8] : 8'd0;
    assign idx_next = r_idx + LENGTH_WIDTH'(1);
    assign pay_end  = CMP_W'(idx_next) >= CMP_W'(r_len);

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_rsv      = r_rsv;
        n_len      = r_len;
        n_len_hi   = r_len_hi;
        n_top      = r_top;
        n_opcode   = r_opcode;
        n_fin      = r_fin;
        n_mask     = r_mask;
        n_key      = r_key;
        n_idx      = r_idx;
        emit       = 1'b0;
        err        = 1'b0;
        err_code   = E_RSV;
        len_done   = 1'b0;
        hdr_done   = 1'b0;
        chk_len    = r_len;
        chk_hi     = r_len_hi;
        n_kind     = K_HEADER;
        n_res_fin  = 1'b0;
        n_res_op   = 4'd0;
        n_res_mask = 1'b0;
        n_res_len  = '0;
        n_res_data = 8'd0;
        n_res_err  = E_RSV;
        n_res_last = 1'b0;

        case (r_phase)
            PH_HDR0: begin
                n_fin    = r_in_byte[7];
                n_opcode = r_in_byte[3:0];
                n_rsv    = (r_in_byte & RSV_MASK) != 8'd0;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                if (r_rsv) begin
                    err      = 1'b1;
                    err_code = E_RSV;
                end else begin
                    n_mask   = r_in_byte[7];
                    n_top    = 1'b0;
                    n_len_hi = 1'b0;
                    n_len    = '0;
                    if (r_in_byte[6:0] == LEN7_EXT16) begin
                        n_phase = PH_EXT;
                        n_cnt   = 3'd1;
                    end else if (r_in_byte[6:0] == LEN7_EXT64) begin
                        n_phase = PH_EXT;
                        n_cnt   = 3'd7;
                    end else begin
                        n_len    = LEN_W'(r_in_byte[6:0]);
                        chk_len  = LEN_W'(r_in_byte[6:0]);
                        chk_hi   = 1'b0;
                        len_done = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                n_len    = shifted;
                n_len_hi = shift_hi;
                if (r_cnt == 3'd7) begin
                    n_top = r_in_byte[7];
                end
                if (r_cnt != 3'd0) begin
                    n_cnt = r_cnt - 3'd1;
                end else if (r_top) begin
                    err      = 1'b1;
                    err_code = E_MSB;
                end else begin
                    chk_len  = shifted;
                    chk_hi   = shift_hi;
                    len_done = 1'b1;
                end
            end
            PH_MASK: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_cnt != 3'd0) begin
                    n_cnt = r_cnt - 3'd1;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            PH_PAY: begin
                emit       = 1'b1;
                n_kind     = K_DATA;
                n_res_fin  = r_fin;
                n_res_op   = r_opcode;
                n_res_mask = r_mask;
                n_res_len  = r_len;
                n_res_data = r_in_byte ^ key_byte;
                n_res_last = pay_end;
                n_idx      = idx_next;
                if (pay_end) begin
                    n_phase = PH_HDR0;
                    n_idx   = '0;
                end
            end
            default: begin
                n_phase = PH_HDR0;
                n_cnt   = 3'd0;
                n_idx   = '0;
            end
        endcase

        if (len_done) begin
            if (!r_fin || (r_opcode[3] && (chk_hi || chk_len > CTRL_MAX_LEN))) begin
                err      = 1'b1;
                err_code = E_FRAG;
            end else if (r_opcode == OP_CLOSE && !chk_hi && chk_len == LEN_W'(1)) begin
                err      = 1'b1;
                err_code = E_CLOSE;
            end else if (n_mask) begin
                n_phase = PH_MASK;
                n_cnt   = 3'd3;
                n_key   = 32'd0;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            if (chk_hi || chk_len > r_max) begin
                err      = 1'b1;
                err_code = E_BIG;
            end else begin
                emit       = 1'b1;
                n_kind     = K_HEADER;
                n_res_fin  = r_fin;
                n_res_op   = r_opcode;
                n_res_mask = n_mask;
                n_res_len  = chk_len;
                n_res_last = chk_len == '0;
                n_idx      = '0;
                n_phase    = (chk_len == '0) ? PH_HDR0 : PH_PAY;
            end
        end

        if (err) begin
            emit       = 1'b1;
            n_kind     = K_ERROR;
            n_res_fin  = 1'b0;
            n_res_op   = 4'd0;
            n_res_mask = 1'b0;
            n_res_len  = '0;
            n_res_data = 8'd0;
            n_res_err  = err_code;
            n_res_last = 1'b0;
            n_phase    = PH_HDR0;
            n_cnt      = 3'd0;
            n_rsv      = 1'b0;
            n_len      = '0;
            n_len_hi   = 1'b0;
            n_top      = 1'b0;
            n_mask     = 1'b0;
            n_idx      = '0;
        end
    end

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max <= i_cfg_max_payload;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv || !r_in_valid) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((adv || !r_in_valid) && i_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_cnt    <= 3'd0;
            r_rsv    <= 1'b0;
            r_len    <= '0;
            r_len_hi <= 1'b0;
            r_top    <= 1'b0;
            r_opcode <= 4'd0;
            r_fin    <= 1'b0;
            r_mask   <= 1'b0;
            r_key    <= 32'd0;
            r_idx    <= '0;
        end else if (fire) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_rsv    <= n_rsv;
            r_len    <= n_len;
            r_len_hi <= n_len_hi;
            r_top    <= n_top;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_mask   <= n_mask;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_kind     <= n_kind;
            r_res_fin  <= n_res_fin;
            r_res_op   <= n_res_op;
            r_res_mask <= n_res_mask;
            r_res_len  <= n_res_len;
            r_res_data <= n_res_data;
            r_res_err  <= n_res_err;
            r_res_last <= n_res_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_fin_bit        = r_res_fin;
    assign o_frame_opcode   = r_res_op;
    assign o_was_masked     = r_res_mask;
    assign o_payload_length = r_res_len;
    assign o_data_byte      = r_res_data;
    assign o_error_code     = r_res_err;
    assign o_last           = r_res_last;

    `AST_IMP(a_err_clean, i_clk, i_rst_n, r_out_valid && r_kind == K_ERROR, r_res_len == '0 && r_res_data == 8'd0 && !r_res_last && !r_res_fin)
    `AST_IMP(a_pay_len_fits, i_clk, i_rst_n, r_phase == PH_PAY, !r_len_hi && r_len != '0)
    `AST_IMP(a_pay_idx_below, i_clk, i_rst_n, r_phase == PH_PAY, CMP_W'(r_idx) < CMP_W'(r_len))
    `AST_NEXT(a_hold_result, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid && $stable(r_kind) && $stable(r_res_data))

endmodule

FILE: tb/websocket_frame_deframer_checker.sv
// Checker for the WebSocket frame deframer: predicts results per accepted word and compares.
`timescale 1ns / 1ps
module websocket_frame_deframer_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [wsdf_pkg::LEN_W-1:0] i_cfg_max_payload,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_kind,
    input  logic                       i_fin_bit,
    input  logic [3:0]                 i_frame_opcode,
    input  logic                       i_was_masked,
    input  logic [wsdf_pkg::LEN_W-1:0] i_payload_length,
    input  logic [7:0]                 i_data_byte,
    input  logic [2:0]                 i_error_code,
    input  logic                       i_last,
    output int                         o_fail_count,
    output int                         o_pending
);
    import wsdf_pkg::*;

    typedef struct packed {
        t_kind            kind;
        logic             fin;
        logic [3:0]       opcode;
        logic             masked;
        logic [LEN_W-1:0] plen;
        logic [7:0]       dbyte;
        t_err             ecode;
        logic             last;
    } t_frame_result;

    t_frame_result    expected_q [$];
    int               fails = 0;

    t_phase                      ph;
    logic [2:0]                  fld_cnt;
    logic [63:0]                 len_acc;
    logic [3:0]                  hop;
    logic                        hfin;
    logic                        hmask;
    logic [31:0]                 mkey;
    logic [LENGTH_WIDTH_DEF-1:0] pidx;
    logic [LEN_W-1:0]            max_len;

    task automatic add_expected(input t_frame_result r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic clear_frame();
        ph      = PH_HDR0;
        fld_cnt = 3'd0;
        len_acc = 64'd0;
        hop     = 4'd0;
        hfin    = 1'b0;
        hmask   = 1'b0;
        mkey    = 32'd0;
        pidx    = '0;
    endtask

    task automatic push_error(input t_err code);
        t_frame_result r;
        r       = '0;
        r.kind  = K_ERROR;
        r.ecode = code;
        add_expected(r);
        clear_frame();
    endtask

    task automatic header_or_limit();
        t_frame_result r;
        if (len_acc > {40'd0, max_len}) begin
            push_error(E_BIG);
        end else begin
            r        = '0;
            r.kind   = K_HEADER;
            r.fin    = hfin;
            r.opcode = hop;
            r.masked = hmask;
            r.plen   = len_acc[LEN_W-1:0];
            r.ecode  = E_RSV;
            r.last   = (len_acc == 64'd0);
            add_expected(r);
            pidx = '0;
            ph   = (len_acc == 64'd0) ? PH_HDR0 : PH_PAY;
        end
    endtask

    task automatic length_checked();
        if (!hfin || (hop[3] && len_acc > {40'd0, CTRL_MAX_LEN})) begin
            push_error(E_FRAG);
        end else if (hop == OP_CLOSE && len_acc == 64'd1) begin
            push_error(E_CLOSE);
        end else if (hmask) begin
            ph      = PH_MASK;
            fld_cnt = 3'd3;
            mkey    = 32'd0;
        end else begin
            header_or_limit();
        end
    endtask

    task automatic predict_word(input logic [7:0] b);
        logic [6:0]                  len7;
        logic [7:0]                  kb;
        logic [LENGTH_WIDTH_DEF-1:0] nxt;
        logic                        done;
        t_frame_result               r;
        case (ph)
            PH_HDR0: begin
                hfin    = b[7];
                hop     = b[3:0];
                // reserved bits are only reported once the second byte is in
                fld_cnt = ((b & RSV_MASK) != 8'd0) ? 3'd1 : 3'd0;
                ph      = PH_HDR1;
            end
            PH_HDR1: begin
                len7 = b[6:0];
                if (fld_cnt != 3'd0) begin
                    push_error(E_RSV);
                end else begin
                    hmask   = b[7];
                    len_acc = 64'd0;
                    if (len7 == LEN7_EXT16) begin
                        ph      = PH_EXT;
                        fld_cnt = 3'd1;
                    end else if (len7 == LEN7_EXT64) begin
                        ph      = PH_EXT;
                        fld_cnt = 3'd7;
                    end else begin
                        len_acc = 64'(len7);
                        length_checked();
                    end
                end
            end
            PH_EXT: begin
                len_acc = {len_acc[55:0], b};
                if (fld_cnt != 3'd0) begin
                    fld_cnt = fld_cnt - 3'd1;
                end else if (len_acc[63]) begin
                    push_error(E_MSB);
                end else begin
                    length_checked();
                end
            end
            PH_MASK: begin
                mkey = {mkey[23:0], b};
                if (fld_cnt != 3'd0) begin
                    fld_cnt = fld_cnt - 3'd1;
                end else begin
                    header_or_limit();
                end
            end
            PH_PAY: begin
                // first key byte is the most significant
                kb       = hmask ? 8'(mkey >> (8 * (3 - pidx[1:0]))) : 8'h00;
                nxt      = pidx + 1'b1;
                done     = (64'(nxt) >= len_acc);
                r        = '0;
                r.kind   = K_DATA;
                r.fin    = hfin;
                r.opcode = hop;
                r.masked = hmask;
                r.plen   = len_acc[LEN_W-1:0];
                r.dbyte  = b ^ kb;
                r.ecode  = E_RSV;
                r.last   = done;
                add_expected(r);
                pidx = nxt;
                if (done) clear_frame();
            end
            default: begin
                clear_frame();
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result e;
        if (!i_rst_n) begin
            max_len = MAX_PAYLOAD_RST;
            clear_frame();
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) max_len = i_cfg_max_payload;
            if (i_in_valid && !i_in_stall) predict_word(i_in_byte);
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result word, kind %0h", $time, i_kind);
                    fails++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("kind", 32'(e.kind), 32'(i_kind));
                    check_field("fin_bit", 32'(e.fin), 32'(i_fin_bit));
                    check_field("frame_opcode", 32'(e.opcode), 32'(i_frame_opcode));
                    check_field("was_masked", 32'(e.masked), 32'(i_was_masked));
                    check_field("payload_length", 32'(e.plen), 32'(i_payload_length));
                    check_field("data_byte", 32'(e.dbyte), 32'(i_data_byte));
                    check_field("error_code", 32'(e.ecode), 32'(i_error_code));
                    check_field("last", 32'(e.last), 32'(i_last));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

FILE: tb/tb_websocket_frame_deframer.sv
// Testbench top for the WebSocket frame deframer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 120;
    localparam int PHASE_WORDS    = 60;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_BIN  = 4'h2;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             tx_valid  = 1'b0;
    logic             tx_stall;
    logic [7:0]       tx_byte   = 8'd0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_max   = '0;
    logic             rx_valid;
    logic             rx_stall  = 1'b0;
    logic [1:0]       rx_kind;
    logic             rx_fin;
    logic [3:0]       rx_opcode;
    logic             rx_masked;
    logic [LEN_W-1:0] rx_plen;
    logic [7:0]       rx_data;
    logic [2:0]       rx_ecode;
    logic             rx_last;

    int  fail_count;
    int  pending;
    int  sent_in_phase = 0;
    int  idle_cycles   = 0;
    int  rx_hold_len   = 0;
    bit  tx_fast       = 1'b0;
    bit  rx_fast       = 1'b0;

    logic [7:0] directed_q [$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    websocket_frame_deframer DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (tx_valid),
        .o_stall           (tx_stall),
        .i_byte_in         (tx_byte),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_max_payload (cfg_max),
        .o_valid           (rx_valid),
        .i_stall           (rx_stall),
        .o_kind            (rx_kind),
        .o_fin_bit         (rx_fin),
        .o_frame_opcode    (rx_opcode),
        .o_was_masked      (rx_masked),
        .o_payload_length  (rx_plen),
        .o_data_byte       (rx_data),
        .o_error_code      (rx_ecode),
        .o_last            (rx_last)
    );

    websocket_frame_deframer_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (tx_valid),
        .i_in_stall        (tx_stall),
        .i_in_byte         (tx_byte),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_max_payload (cfg_max),
        .i_out_valid       (rx_valid),
        .i_out_stall       (rx_stall),
        .i_kind            (rx_kind),
        .i_fin_bit         (rx_fin),
        .i_frame_opcode    (rx_opcode),
        .i_was_masked      (rx_masked),
        .i_payload_length  (rx_plen),
        .i_data_byte       (rx_data),
        .i_error_code      (rx_ecode),
        .i_last            (rx_last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // no progress on any channel for too long ends the run
    always @(posedge clk) begin
        if (rst_n) begin
            if ((tx_valid && !tx_stall) || (rx_valid && !rx_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver: random stall per word, plus a single long hold
    initial begin
        int w;
        forever begin
            @(negedge clk);
            if (rx_hold_len > 0) begin
                w = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                w = rx_fast ? 0 : $urandom_range(0, 3);
            end
            if (w > 0) begin
                rx_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            rx_stall = 1'b0;
            do @(posedge clk); while (!rx_valid);
        end
    end

    task automatic put_byte(input logic [7:0] b);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0) begin
            tx_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        tx_valid = 1'b1;
        tx_byte  = b;
        do @(posedge clk); while (tx_stall);
        sent_in_phase++;
    endtask

    task automatic drain();
        @(negedge clk);
        tx_valid = 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_max   = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic bit frame_ok(input logic fin, input logic [2:0] rsv,
                                    input logic [3:0] op, input logic [63:0] len,
                                    input logic [LEN_W-1:0] max_now);
        return fin && rsv == 3'd0 && !len[63] && !(op[3] && len > 64'd125)
            && !(op == OP_CLOSE && len == 64'd1) && len <= {40'd0, max_now};
    endfunction

    task automatic send_frame(input logic [LEN_W-1:0] max_now);
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  op;
        logic        mask;
        logic [63:0] len;
        logic [31:0] key;
        logic [6:0]  len7;
        int          sel;
        int          form;
        int          n_pay;
        int          i;
        bit          ok;
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
        fin  = ($urandom_range(0, 9) != 0);
        rsv  = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
        sel  = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: op = OP_TEXT;
            3, 4:    op = OP_BIN;
            5:       op = OP_CONT;
            6:       op = OP_CLOSE;
            7:       op = OP_PING;
            8:       op = OP_PONG;
            default: op = 4'($urandom);
        endcase
        mask = 1'($urandom);
        sel  = $urandom_range(0, 19);
        if (sel <= 14)      len = 64'($urandom_range(0, 12));
        else if (sel == 15) len = 64'($urandom_range(120, 130));
        else if (sel == 16) len = 64'($urandom_range(0, 16'hFFFF));
        else if (sel == 17) len = 64'($urandom_range(0, 24'hFFFFFF));
        else if (sel == 18) len = {1'b1, 31'($urandom), 32'($urandom)};
        else                len = {32'($urandom) | 32'h1, 32'($urandom)};
        ok = frame_ok(fin, rsv, op, len, max_now);
        // keep accepted payloads short
        if (ok && len > 64'd64 && ($urandom_range(0, 3) != 0 || len > 64'd200)) begin
            len = 64'($urandom_range(0, 12));
            ok  = frame_ok(fin, rsv, op, len, max_now);
        end
        sel = $urandom_range(0, 19);
        if (len > 64'hFFFF)       form = 2;
        else if (len >= 64'd126)  form = 1 + $urandom_range(0, 1);
        else                      form = (sel < 14) ? 0 : (sel < 17) ? 1 : 2;
        len7 = (form == 0) ? len[6:0] : (form == 1) ? LEN7_EXT16 : LEN7_EXT64;
        put_byte({fin, rsv, op});
        put_byte({mask, len7});
        if (rsv != 3'd0) return;
        if (form == 1) begin
            put_byte(len[15:8]);
            put_byte(len[7:0]);
        end else if (form == 2) begin
            for (i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
        end
        if (len[63] || !fin || (op[3] && len > 64'd125) || (op == OP_CLOSE && len == 64'd1))
            return;
        if (mask) begin
            key = $urandom;
            for (i = 3; i >= 0; i--) put_byte(key[8*i +: 8]);
        end
        if (!ok) return;
        n_pay = int'(len);
        if ($urandom_range(0, 24) == 0) n_pay = $urandom_range(0, n_pay);
        repeat (n_pay) put_byte(8'($urandom));
    endtask

    initial begin
        logic [LEN_W-1:0] v;
        int               p;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset limit: empty frame, reserved bits, fragment, close of one byte,
        // oversized control, 64-bit length with top bit, masked payload
        directed_q = '{8'h81, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h88, 8'h01,
                       8'h89, 8'h7E, 8'h00, 8'h7E,
                       8'h82, 8'h7F, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h82, 8'h82, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'hFF, 8'h00};
        foreach (directed_q[k]) put_byte(directed_q[k]);

        // zero limit: masked frame too large after the key
        drain();
        write_max('0);
        directed_q = '{8'h82, 8'h81, 8'h11, 8'h22, 8'h33, 8'h44};
        foreach (directed_q[k]) put_byte(directed_q[k]);

        for (p = 0; p < 7; p++) begin
            drain();
            case (p)
                0:       v = 24'hFFFFFF;
                1:       v = 24'd0;
                2:       v = 24'd125;
                3:       v = 24'd1;
                4:       v = 24'($urandom_range(0, 40));
                5:       v = MAX_PAYLOAD_RST;
                default: v = 24'($urandom);
            endcase
            write_max(v);
            if (p == 2) rx_hold_len = LONG_HOLD;
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_WORDS) send_frame(v);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
